@@ hw/rtl/fbfs_pkg.sv @@
package fbfs_pkg;

  localparam int DIM_W   = 13;           // config register width
  localparam int FLD_W   = 16;           // coordinate field width
  localparam int PIX_W   = 32;
  localparam int PROD_W  = 2 * DIM_W;    // row times stride
  localparam int WIDE_W  = PROD_W + 2;   // address sums that never wrap
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // input action codes
  localparam logic [2:0] ACT_PUT    = 3'd0;
  localparam logic [2:0] ACT_GET    = 3'd1;
  localparam logic [2:0] ACT_FILL   = 3'd2;
  localparam logic [2:0] ACT_SCROLL = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // register indexes on the apb port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STRIDE = 2'd2;

  typedef enum logic [2:0] {
    K_NOP,
    K_PUT,
    K_GET,
    K_RECT,
    K_SCROLL
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [DIM_W-1:0]  mul_y;      // first row (or scroll count), multiplied by stride in the back end
    logic [DIM_W-1:0]  x0;         // first column
    logic [DIM_W-1:0]  col_end;    // exclusive column limit
    logic [DIM_W-1:0]  row_end;    // exclusive row limit
    logic [DIM_W-1:0]  copy_rows;  // rows moved by a scroll
    logic [DIM_W-1:0]  band_y0;    // first row of the scroll band
    logic              band_en;
    logic [PIX_W-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] stride;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PIX,
    ST_GETW,
    ST_RECT,
    ST_COPY,
    ST_BMUL,
    ST_DONE
  } st_t;

endpackage

@@ hw/rtl/framebuffer_fill_scroll_engine.sv @@
// framebuffer fill and scroll engine: a frame store of MEM_WORDS 32-bit pixels, pixel
// (x, y) at word y * row_stride + x, driven by one command per input beat (put, get,
// fill rectangle, scroll up with bottom band, clear). every command returns exactly one
// result beat; read_pixel carries the pixel for get and zero otherwise. a front stage
// clips and classifies each command against the screen registers and queues it (4 deep),
// so commands keep being taken while the back end works, until the queue fills. the back
// end owns the store, which has one write and one registered read port and moves one
// pixel per cycle while it paints or copies a row; a scroll copy moves min((height -
// lines) * stride, MEM_WORDS) words before the band is painted. the store powers up
// undefined and is not cleared by reset; reading a word never written is not meaningful.
// screen_width, screen_height and row_stride (13 bits, reset 64) sit at byte addresses
// 0, 4 and 8 and may only be written while no command is in flight.
module framebuffer_fill_scroll_engine import fbfs_pkg::*; #(
  parameter int MEM_WORDS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  // command channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_action,
  input  logic [FLD_W-1:0] in_x,
  input  logic [FLD_W-1:0] in_y,
  input  logic [FLD_W-1:0] in_w,
  input  logic [FLD_W-1:0] in_h,
  input  logic [PIX_W-1:0] in_color,
  input  logic [FLD_W-1:0] in_scroll_lines,
  input  logic [FLD_W-1:0] in_band_height,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_read_pixel,
  // apb register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] stride_r;
  logic             cfg_we;
  logic [1:0]       reg_idx;
  cfg_t             cfg;

  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  // register file, written on the apb access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(64);
      height_r <= DIM_W'(64);
      stride_r <= DIM_W'(64);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_STRIDE: stride_r <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_STRIDE: prdata = 32'(stride_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{width: width_r, height: height_r, stride: stride_r};

  // front: clip and classify each command beat
  fbfs_front u_front (
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_w            (in_w),
    .in_h            (in_h),
    .in_color        (in_color),
    .in_scroll_lines (in_scroll_lines),
    .in_band_height  (in_band_height),
    .q_stat          (q_stat),
    .push            (push),
    .cmd             (push_cmd)
  );

  // decoupling queue between front and back
  fbfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: frame store and the pixel walker
  fbfs_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_pixel (out_read_pixel)
  );

  // back end never pulls from an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // front never pushes into a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // queue status flags stay consistent
  a_q_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule

@@ hw/rtl/fbfs_front.sv @@
module fbfs_front import fbfs_pkg::*; (
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [FLD_W-1:0]  in_x,
  input  logic [FLD_W-1:0]  in_y,
  input  logic [FLD_W-1:0]  in_w,
  input  logic [FLD_W-1:0]  in_h,
  input  logic [PIX_W-1:0]  in_color,
  input  logic [FLD_W-1:0]  in_scroll_lines,
  input  logic [FLD_W-1:0]  in_band_height,
  input  q_stat_t           q_stat,
  output logic              push,
  output cmd_t              cmd
);

  logic [FLD_W:0]   col_sum;
  logic [FLD_W:0]   row_sum;
  logic [DIM_W-1:0] col_end_c;
  logic [DIM_W-1:0] row_end_c;
  logic             on_screen;
  logic             fill_ok;
  logic             full_ok;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    col_sum   = {1'b0, in_x} + {1'b0, in_w};
    row_sum   = {1'b0, in_y} + {1'b0, in_h};
    col_end_c = (col_sum > (FLD_W+1)'(cfg.width))  ? cfg.width  : col_sum[DIM_W-1:0];
    row_end_c = (row_sum > (FLD_W+1)'(cfg.height)) ? cfg.height : row_sum[DIM_W-1:0];
    on_screen = (in_x < FLD_W'(cfg.width)) && (in_y < FLD_W'(cfg.height));
    fill_ok   = (in_x < FLD_W'(col_end_c)) && (in_y < FLD_W'(row_end_c));
    full_ok   = (cfg.width != '0) && (cfg.height != '0);

    cmd.kind      = K_NOP;
    cmd.mul_y     = in_y[DIM_W-1:0];
    cmd.x0        = in_x[DIM_W-1:0];
    cmd.col_end   = col_end_c;
    cmd.row_end   = row_end_c;
    cmd.copy_rows = cfg.height - in_scroll_lines[DIM_W-1:0];
    cmd.band_y0   = cfg.height - in_band_height[DIM_W-1:0];
    cmd.band_en   = (in_band_height <= FLD_W'(cfg.height)) && (in_band_height != '0)
                    && (cfg.width != '0);
    cmd.color     = in_color;

    unique case (in_action)
      ACT_PUT: begin
        if (on_screen) cmd.kind = K_PUT;
      end
      ACT_GET: begin
        if (on_screen) cmd.kind = K_GET;
      end
      ACT_FILL: begin
        if (fill_ok) cmd.kind = K_RECT;
      end
      ACT_SCROLL: begin
        cmd.x0      = '0;
        cmd.col_end = cfg.width;
        cmd.row_end = cfg.height;
        if (in_scroll_lines >= FLD_W'(cfg.height)) begin
          // scrolled past the screen: whole screen cleared
          cmd.mul_y = '0;
          if (full_ok) cmd.kind = K_RECT;
        end else begin
          cmd.mul_y = in_scroll_lines[DIM_W-1:0];
          cmd.kind  = K_SCROLL;
        end
      end
      ACT_CLEAR: begin
        cmd.x0      = '0;
        cmd.mul_y   = '0;
        cmd.col_end = cfg.width;
        cmd.row_end = cfg.height;
        if (full_ok) cmd.kind = K_RECT;
      end
      default: begin
        cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

@@ hw/rtl/fbfs_queue.sv @@
module fbfs_queue import fbfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign head = slot_r[rd_ptr_r];
  assign stat = '{full:  (count_r == (Q_PTR_W+1)'(Q_DEPTH)),
                  empty: (count_r == '0)};

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (Q_PTR_W+1)'(1);
        2'b01:   count_r <= count_r - (Q_PTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/fbfs_back.sv @@
module fbfs_back import fbfs_pkg::*; #(
  parameter int MEM_WORDS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  cmd_t             head,
  input  q_stat_t          q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_read_pixel
);

  localparam int AW    = $clog2(MEM_WORDS);
  localparam int CNT_W = $clog2(MEM_WORDS + 1);
  localparam logic [WIDE_W-1:0] MEM_LIM = WIDE_W'(MEM_WORDS);
  localparam logic [CNT_W-1:0]  CNT_LIM = CNT_W'(MEM_WORDS);

  logic [PIX_W-1:0] mem [MEM_WORDS];

  st_t               st_r, st_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [WIDE_W-1:0] base_r, base_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PIX_W-1:0]  res_r, res_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_zero_r, pend_zero_nxt;
  logic [AW-1:0]     pend_dst_r, pend_dst_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_data_r, out_data_nxt;
  logic [PIX_W-1:0]  mem_q_r;

  logic [DIM_W-1:0]  mul_a;
  logic [PROD_W-1:0] prod;
  logic [WIDE_W-1:0] addr;
  logic              st_we;
  logic              wr_en;
  logic [AW-1:0]     wr_idx;
  logic [PIX_W-1:0]  wr_data;
  logic [AW-1:0]     rd_idx;

  assign out_valid      = out_valid_r;
  assign out_read_pixel = out_data_r;

  assign prod = mul_a * cfg.stride;
  assign addr = base_r + WIDE_W'(col_r);

  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    base_nxt      = base_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    pend_nxt      = 1'b0;
    pend_zero_nxt = pend_zero_r;
    pend_dst_nxt  = pend_dst_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    mul_a         = cmd_r.mul_y;
    st_we         = 1'b0;
    rd_idx        = addr[AW-1:0];

    unique case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          res_nxt = '0;
          st_nxt  = (head.kind == K_NOP) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        base_nxt = WIDE_W'(prod);
        cnt_nxt  = '0;
        unique case (cmd_r.kind)
          K_SCROLL: begin
            row_nxt = cmd_r.copy_rows;
            col_nxt = '0;
            st_nxt  = ST_COPY;
          end
          K_RECT: begin
            row_nxt = cmd_r.mul_y;
            col_nxt = cmd_r.x0;
            st_nxt  = ST_RECT;
          end
          K_PUT, K_GET: begin
            col_nxt = cmd_r.x0;
            st_nxt  = ST_PIX;
          end
          default: begin
            st_nxt = ST_DONE;
          end
        endcase
      end
      ST_PIX: begin
        st_nxt = ST_DONE;
        if (addr < MEM_LIM) begin
          if (cmd_r.kind == K_GET) st_nxt = ST_GETW;
          else                     st_we  = 1'b1;
        end
      end
      ST_GETW: begin
        res_nxt = mem_q_r;
        st_nxt  = ST_DONE;
      end
      ST_RECT: begin
        if (base_r >= MEM_LIM || row_r >= cmd_r.row_end) begin
          st_nxt = ST_DONE;
        end else if (col_r < cmd_r.col_end && addr < MEM_LIM) begin
          st_we   = 1'b1;
          col_nxt = col_r + DIM_W'(1);
        end else begin
          // row finished or ran off the store
          row_nxt  = row_r + DIM_W'(1);
          base_nxt = base_r + WIDE_W'(cfg.stride);
          col_nxt  = cmd_r.x0;
        end
      end
      ST_COPY: begin
        if (row_r == '0 || cfg.stride == '0 || cnt_r >= CNT_LIM) begin
          st_nxt = cmd_r.band_en ? ST_BMUL : ST_DONE;
        end else begin
          rd_idx        = base_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_dst_nxt  = cnt_r[AW-1:0];
          pend_zero_nxt = (base_r >= MEM_LIM);
          cnt_nxt       = cnt_r + CNT_W'(1);
          base_nxt      = base_r + WIDE_W'(1);
          if (col_r == cfg.stride - DIM_W'(1)) begin
            col_nxt = '0;
            row_nxt = row_r - DIM_W'(1);
          end else begin
            col_nxt = col_r + DIM_W'(1);
          end
        end
      end
      ST_BMUL: begin
        mul_a    = cmd_r.band_y0;
        base_nxt = WIDE_W'(prod);
        row_nxt  = cmd_r.band_y0;
        col_nxt  = cmd_r.x0;
        st_nxt   = ST_RECT;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // copy write lands in the cycle after its read
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_idx  = pend_dst_r;
      wr_data = pend_zero_r ? '0 : mem_q_r;
    end else begin
      wr_en   = st_we;
      wr_idx  = addr[AW-1:0];
      wr_data = cmd_r.color;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    mem_q_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    base_r      <= base_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    pend_zero_r <= pend_zero_nxt;
    pend_dst_r  <= pend_dst_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
